### rtl/ppft_pkg.sv
`default_nettype none
package ppft_pkg;

	// Longest rotation chain the angle table supports
	localparam int MAX_STAGES = 24;

	// Rotation angles atan(2^-i), 32-bit binary angle, 2^32 is a full turn
	localparam logic [31:0] ATAN_TAB [0:MAX_STAGES-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Per-object fields that ride alongside the sine/cosine pipeline
	typedef struct packed {
		logic               mode;
		logic signed [31:0] ego_x;
		logic signed [31:0] ego_y;
		logic        [15:0] heading;
		logic signed [32:0] px;
		logic signed [32:0] py;
		logic signed [23:0] vx;
		logic signed [23:0] vy;
	} side_t;

endpackage
`default_nettype wire

### rtl/planar_pose_frame_transform_top.sv
`default_nettype none
// Planar pose frame transform. Each input beat carries an ego pose and one
// object (position, heading, velocity); tuser selects the direction, 0 for
// vehicle frame to world frame and 1 for world frame to vehicle frame. The
// block accepts one beat per clock while the output is not stalled and
// returns one result beat per input beat, in order. The pipeline is the
// sine/cosine rotation chain (ROTATION_STAGES stages, capped at 24), one
// micro-rotation per pipeline stage, plus one stage each for angle
// preparation, sign fold and clamp, the product multipliers, the rounding
// adders and the offset/saturation logic. Valid bits travel with the data
// and each stage holds independently, so bubbles close up under
// back-pressure. Positions and velocities clamp on overflow and tuser on
// the output flags that a clamp acted.
module planar_pose_frame_transform_top #(
	parameter int ROTATION_STAGES = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// ego_pos_x[31:0], ego_pos_y[63:32], ego_heading[79:64], obj_pos_x[111:80],
	// obj_pos_y[143:112], obj_heading[159:144], obj_vel_x[183:160],
	// obj_vel_y[207:184]
	input  wire  [207:0] s_axis_tdata,
	// mode[0]
	input  wire          s_axis_tuser,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// out_pos_x[31:0], out_pos_y[63:32], out_heading[79:64],
	// out_vel_x[103:80], out_vel_y[127:104]
	output logic [127:0] m_axis_tdata,
	// saturated[0]
	output logic         m_axis_tuser
);

	localparam logic [15:0]        QUARTER_TURN = 16'h4000;
	localparam logic               MODE_TO_WORLD = 1'b0;
	localparam logic signed [65:0] RND_POS = 66'sd536870912;
	localparam logic signed [56:0] RND_VEL = 57'sd536870912;

	// Unpack the input beat
	logic               in_mode;
	logic signed [31:0] in_ego_x, in_ego_y, in_obj_x, in_obj_y;
	logic        [15:0] in_ego_h, in_obj_h;
	logic signed [23:0] in_vel_x, in_vel_y;

	assign in_mode  = s_axis_tuser;
	assign in_ego_x = s_axis_tdata[31:0];
	assign in_ego_y = s_axis_tdata[63:32];
	assign in_ego_h = s_axis_tdata[79:64];
	assign in_obj_x = s_axis_tdata[111:80];
	assign in_obj_y = s_axis_tdata[143:112];
	assign in_obj_h = s_axis_tdata[159:144];
	assign in_vel_x = s_axis_tdata[183:160];
	assign in_vel_y = s_axis_tdata[207:184];

	// Handshake chain, back to front
	logic v_s1, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s4, rdy_s5, rdy_s6;
	logic cor_in_ready, cor_valid;

	assign rdy_s6 = !v_s6 || m_axis_tready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s1 = !v_s1 || cor_in_ready;
	assign s_axis_tready = rdy_s1;

	// Stage 1: rotation angle, heading, source offset
	logic        [15:0] ang, ang_fold, ang_turn, hd;
	logic               flip;
	logic signed [32:0] dx, dy;

	always_comb begin
		if (in_mode == MODE_TO_WORLD) begin
			ang = QUARTER_TURN - in_ego_h;
			hd  = in_obj_h + in_ego_h - QUARTER_TURN;
			dx  = {in_obj_x[31], in_obj_x};
			dy  = {in_obj_y[31], in_obj_y};
		end else begin
			ang = in_ego_h - QUARTER_TURN;
			hd  = in_obj_h - in_ego_h + QUARTER_TURN;
			dx  = {in_obj_x[31], in_obj_x} - {in_ego_x[31], in_ego_x};
			dy  = {in_obj_y[31], in_obj_y} - {in_ego_y[31], in_ego_y};
		end
		// Fold the half turn around 180 degrees into the right half plane
		ang_turn = ang + QUARTER_TURN;
		flip     = ang_turn[15];
		ang_fold = ang ^ {flip, 15'b0};
	end

	logic signed [32:0] z_s1;
	logic               flip_s1;
	ppft_pkg::side_t    side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			z_s1            <= {ang_fold[15], ang_fold, 16'b0};
			flip_s1         <= flip;
			side_s1.mode    <= in_mode;
			side_s1.ego_x   <= in_ego_x;
			side_s1.ego_y   <= in_ego_y;
			side_s1.heading <= hd;
			side_s1.px      <= dx;
			side_s1.py      <= dy;
			side_s1.vx      <= in_vel_x;
			side_s1.vy      <= in_vel_y;
		end
	end

	// Sine and cosine pipeline
	logic signed [31:0] cor_cos, cor_sin;
	ppft_pkg::side_t    cor_side;

	ppft_cordic #(
		.ROTATION_STAGES(ROTATION_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_ready (cor_in_ready),
		.in_z     (z_s1),
		.in_flip  (flip_s1),
		.in_side  (side_s1),
		.out_valid(cor_valid),
		.out_ready(rdy_s4),
		.out_cos  (cor_cos),
		.out_sin  (cor_sin),
		.out_side (cor_side)
	);

	// Stage 4: products
	logic signed [64:0] pxc_s4, pys_s4, pyc_s4, pxs_s4;
	logic signed [55:0] vxc_s4, vys_s4, vyc_s4, vxs_s4;
	logic               mode_s4;
	logic signed [31:0] ego_x_s4, ego_y_s4;
	logic        [15:0] hd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= cor_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && cor_valid) begin
			pxc_s4   <= cor_side.px * cor_cos;
			pys_s4   <= cor_side.py * cor_sin;
			pyc_s4   <= cor_side.py * cor_cos;
			pxs_s4   <= cor_side.px * cor_sin;
			vxc_s4   <= cor_side.vx * cor_cos;
			vys_s4   <= cor_side.vy * cor_sin;
			vyc_s4   <= cor_side.vy * cor_cos;
			vxs_s4   <= cor_side.vx * cor_sin;
			mode_s4  <= cor_side.mode;
			ego_x_s4 <= cor_side.ego_x;
			ego_y_s4 <= cor_side.ego_y;
			hd_s4    <= cor_side.heading;
		end
	end

	// Stage 5: sum and round half up to output scale
	logic signed [65:0] sum_px, sum_py;
	logic signed [56:0] sum_vx, sum_vy;

	always_comb begin
		sum_px = $signed({pxc_s4[64], pxc_s4}) + $signed({pys_s4[64], pys_s4}) + RND_POS;
		sum_py = $signed({pyc_s4[64], pyc_s4}) - $signed({pxs_s4[64], pxs_s4}) + RND_POS;
		sum_vx = $signed({vxc_s4[55], vxc_s4}) + $signed({vys_s4[55], vys_s4}) + RND_VEL;
		sum_vy = $signed({vyc_s4[55], vyc_s4}) - $signed({vxs_s4[55], vxs_s4}) + RND_VEL;
	end

	logic signed [35:0] px_s5, py_s5;
	logic signed [26:0] vx_s5, vy_s5;
	logic               mode_s5;
	logic signed [31:0] ego_x_s5, ego_y_s5;
	logic        [15:0] hd_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			px_s5    <= sum_px[65:30];
			py_s5    <= sum_py[65:30];
			vx_s5    <= sum_vx[56:30];
			vy_s5    <= sum_vy[56:30];
			mode_s5  <= mode_s4;
			ego_x_s5 <= ego_x_s4;
			ego_y_s5 <= ego_y_s4;
			hd_s5    <= hd_s4;
		end
	end

	// Stage 6: add ego offset, clamp, flag
	logic signed [36:0] fx, fy;
	logic signed [31:0] cx, cy;
	logic signed [23:0] cvx, cvy;
	logic               sx, sy, svx, svy;

	always_comb begin
		fx = {px_s5[35], px_s5};
		fy = {py_s5[35], py_s5};
		if (mode_s5 == MODE_TO_WORLD) begin
			fx = fx + {{5{ego_x_s5[31]}}, ego_x_s5};
			fy = fy + {{5{ego_y_s5[31]}}, ego_y_s5};
		end
		// Out of range when the bits above the sign are not all copies of it
		sx  = (fx[36:31] != {6{fx[36]}});
		sy  = (fy[36:31] != {6{fy[36]}});
		svx = (vx_s5[26:23] != {4{vx_s5[26]}});
		svy = (vy_s5[26:23] != {4{vy_s5[26]}});
		cx  = sx  ? {fx[36], {31{!fx[36]}}}       : fx[31:0];
		cy  = sy  ? {fy[36], {31{!fy[36]}}}       : fy[31:0];
		cvx = svx ? {vx_s5[26], {23{!vx_s5[26]}}} : vx_s5[23:0];
		cvy = svy ? {vy_s5[26], {23{!vy_s5[26]}}} : vy_s5[23:0];
	end

	logic signed [31:0] pos_x_s6, pos_y_s6;
	logic signed [23:0] vel_x_s6, vel_y_s6;
	logic        [15:0] hd_s6;
	logic               sat_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (rdy_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			pos_x_s6 <= cx;
			pos_y_s6 <= cy;
			vel_x_s6 <= cvx;
			vel_y_s6 <= cvy;
			hd_s6    <= hd_s5;
			sat_s6   <= sx || sy || svx || svy;
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {vel_y_s6, vel_x_s6, hd_s6, pos_y_s6, pos_x_s6};
	assign m_axis_tuser  = sat_s6;

	// An empty output register lets the whole pipe advance
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s6 |-> s_axis_tready)
		else $error("input stalled with empty output register");

	// A rounded item moving forward shows up on the output
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && rdy_s6 |=> m_axis_tvalid)
		else $error("result lost between rounding and output stage");

	// A raised clamp flag comes with a field pinned at a range end
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			(pos_x_s6 == 32'sh7FFFFFFF || pos_x_s6 == -32'sh80000000 ||
			 pos_y_s6 == 32'sh7FFFFFFF || pos_y_s6 == -32'sh80000000 ||
			 vel_x_s6 == 24'sh7FFFFF   || vel_x_s6 == -24'sh800000   ||
			 vel_y_s6 == 24'sh7FFFFF   || vel_y_s6 == -24'sh800000))
		else $error("saturation flag without a clamped field");

endmodule
`default_nettype wire

### rtl/ppft_cordic.sv
`default_nettype none
module ppft_cordic #(
	parameter int ROTATION_STAGES = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire  signed [32:0]         in_z,
	input  wire                        in_flip,
	input  wire  ppft_pkg::side_t      in_side,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic signed [31:0]         out_cos,
	output logic signed [31:0]         out_sin,
	output ppft_pkg::side_t            out_side
);

	localparam int N = (ROTATION_STAGES > ppft_pkg::MAX_STAGES) ?
		ppft_pkg::MAX_STAGES : ROTATION_STAGES;
	localparam logic signed [32:0] INV_GAIN = 33'sd652032874;
	localparam logic signed [32:0] ONE_Q30  = 33'sd1073741824;

	logic signed [32:0] x_s2 [0:N-1];
	logic signed [32:0] y_s2 [0:N-1];
	logic signed [32:0] z_s2 [0:N-1];
	logic               f_s2 [0:N-1];
	ppft_pkg::side_t    side_s2 [0:N-1];
	logic [N-1:0]       v_s2;
	logic [N-1:0]       rdy_s2;

	logic                v_s3;
	logic                rdy_s3;
	logic signed [31:0]  cos_s3;
	logic signed [31:0]  sin_s3;
	ppft_pkg::side_t     side_s3;

	assign rdy_s3   = !v_s3 || out_ready;
	assign in_ready = rdy_s2[0];

	// One micro-rotation per stage
	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_iter
			logic signed [32:0] xi, yi, zi, xn, yn, zn;
			logic               fi, vi, rdy_next;
			ppft_pkg::side_t    si;
			logic signed [32:0] ang;

			if (k == 0) begin : g_first
				assign xi = INV_GAIN;
				assign yi = '0;
				assign zi = in_z;
				assign fi = in_flip;
				assign si = in_side;
				assign vi = in_valid;
			end else begin : g_rest
				assign xi = x_s2[k-1];
				assign yi = y_s2[k-1];
				assign zi = z_s2[k-1];
				assign fi = f_s2[k-1];
				assign si = side_s2[k-1];
				assign vi = v_s2[k-1];
			end

			if (k == N - 1) begin : g_last
				assign rdy_next = rdy_s3;
			end else begin : g_mid
				assign rdy_next = rdy_s2[k+1];
			end

			assign rdy_s2[k] = !v_s2[k] || rdy_next;
			assign ang = $signed({1'b0, ppft_pkg::ATAN_TAB[k]});

			// Rotate toward zero residual angle
			always_comb begin
				if (!zi[32]) begin
					xn = xi - (yi >>> k);
					yn = yi + (xi >>> k);
					zn = zi - ang;
				end else begin
					xn = xi + (yi >>> k);
					yn = yi - (xi >>> k);
					zn = zi + ang;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s2[k] <= 1'b0;
				end else if (rdy_s2[k]) begin
					v_s2[k] <= vi;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy_s2[k] && vi) begin
					x_s2[k]    <= xn;
					y_s2[k]    <= yn;
					z_s2[k]    <= zn;
					f_s2[k]    <= fi;
					side_s2[k] <= si;
				end
			end
		end
	endgenerate

	// Undo the half-turn fold and clamp to unit range
	logic signed [32:0] xf, yf, xc, yc;

	always_comb begin
		xf = f_s2[N-1] ? -x_s2[N-1] : x_s2[N-1];
		yf = f_s2[N-1] ? -y_s2[N-1] : y_s2[N-1];
		if (xf > ONE_Q30) begin
			xc = ONE_Q30;
		end else if (xf < -ONE_Q30) begin
			xc = -ONE_Q30;
		end else begin
			xc = xf;
		end
		if (yf > ONE_Q30) begin
			yc = ONE_Q30;
		end else if (yf < -ONE_Q30) begin
			yc = -ONE_Q30;
		end else begin
			yc = yf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2[N-1]) begin
			cos_s3  <= xc[31:0];
			sin_s3  <= yc[31:0];
			side_s3 <= side_s2[N-1];
		end
	end

	assign out_valid = v_s3;
	assign out_cos   = cos_s3;
	assign out_sin   = sin_s3;
	assign out_side  = side_s3;

endmodule
`default_nettype wire
